FILE: hdl/osn2d_pkg.sv
//------------------------------------------------------------------------------
// osn2d_pkg
// Shared constants and helper functions for the 2D noise unit.
//------------------------------------------------------------------------------
package osn2d_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GEO_BITS = 24;
	localparam int TABLE_AW = 8;
	localparam logic [31:0] STRETCH_Q32 = 32'd907633386;
	localparam logic signed [27:0] GEO_ONE = 28'sd16777216;
	localparam logic signed [27:0] SQ24 = 28'sd6140887;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// gradient lookup: octagon directions
	function automatic logic signed [3:0] grad_x(input logic [2:0] g);
		logic signed [3:0] r;
		case (g)
			3'd0: r = 4'sd5;
			3'd1: r = -4'sd5;
			3'd2: r = 4'sd5;
			3'd3: r = -4'sd5;
			3'd4: r = 4'sd2;
			3'd5: r = -4'sd2;
			3'd6: r = 4'sd2;
			default: r = -4'sd2;
		endcase
		return r;
	endfunction

	function automatic logic signed [3:0] grad_y(input logic [2:0] g);
		logic signed [3:0] r;
		case (g)
			3'd0: r = 4'sd2;
			3'd1: r = 4'sd2;
			3'd2: r = -4'sd2;
			3'd3: r = -4'sd2;
			3'd4: r = 4'sd5;
			3'd5: r = 4'sd5;
			3'd6: r = -4'sd5;
			default: r = -4'sd5;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/osn2d_vertex.sv
//------------------------------------------------------------------------------
// osn2d_vertex
// One vertex contribution: attn^4 * dot(grad, d), pipelined over four stages.
// Input d arrives with the gradient code; term is a combinational product of the fourth-stage registers.
//------------------------------------------------------------------------------
module osn2d_vertex (
	input  logic                clk,
	input  logic signed [27:0]  dx,
	input  logic signed [27:0]  dy,
	input  logic [2:0]          gsel,
	output logic signed [63:0]  term
);

	logic signed [55:0] sqx_s1, sqy_s1;
	logic signed [27:0] dx_s1, dy_s1;
	logic [2:0]         g_s1;
	logic signed [29:0] attn_s2;
	logic signed [33:0] dot_s2;
	logic signed [29:0] a2_s3;
	logic signed [33:0] dot_s3;
	logic signed [29:0] a4_s4;
	logic signed [33:0] dot_s4;
	logic signed [59:0] a2full, a4full;
	logic signed [29:0] attn_c;

	// square offsets
	always_ff @(posedge clk) begin
		sqx_s1 <= dx * dx;
		sqy_s1 <= dy * dy;
		dx_s1 <= dx;
		dy_s1 <= dy;
		g_s1 <= gsel;
	end

	assign attn_c = 30'sd33554432 - 30'(sqx_s1 >>> osn2d_pkg::GEO_BITS)
		- 30'(sqy_s1 >>> osn2d_pkg::GEO_BITS);

	// attenuation and dot product
	always_ff @(posedge clk) begin
		attn_s2 <= (attn_c > 0) ? attn_c : 30'sd0;
		dot_s2 <= 34'(osn2d_pkg::grad_x(g_s1) * dx_s1) + 34'(osn2d_pkg::grad_y(g_s1) * dy_s1);
	end

	assign a2full = attn_s2 * attn_s2;
	always_ff @(posedge clk) begin
		a2_s3 <= 30'(a2full >>> osn2d_pkg::GEO_BITS);
		dot_s3 <= dot_s2;
	end

	assign a4full = a2_s3 * a2_s3;
	always_ff @(posedge clk) begin
		a4_s4 <= 30'(a4full >>> osn2d_pkg::GEO_BITS);
		dot_s4 <= dot_s3;
	end

	assign term = 64'(a4_s4 * dot_s4);

endmodule

FILE: hdl/opensimplex_noise_2d_unit.sv
//------------------------------------------------------------------------------
// opensimplex_noise_2d_unit
// 2D gradient noise from a host-loaded 256-byte permutation table.
//------------------------------------------------------------------------------
// An evaluate item may be started every cycle; busy is always low. Its result
// appears with done high once it has passed through the pipeline. The stages
// are the skew multiply, the skewed coordinates, the squish product, vertex
// selection, two table read stages, the four-stage vertex unit, the sum, the
// reciprocal scaling and the output register. Load items write the table and
// give no result. Load the table only while no evaluate item is in flight,
// since an evaluate item reads the table in its fifth and sixth stages.
// The receiver cannot stall, so results are shown once and dropped.
module opensimplex_noise_2d_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic [7:0]         table_index,
	input  logic [7:0]         table_value,
	output logic               done,
	output logic [15:0]        noise
);

	localparam int LAT = 13;
	localparam logic signed [27:0] ONE = osn2d_pkg::GEO_ONE;
	localparam logic signed [27:0] SQ = osn2d_pkg::SQ24;
	localparam logic signed [65:0] FULL_SCALE = 66'sd94 <<< 48;
	localparam logic [22:0] RECIP_94 = 23'd5711393;

	logic [7:0] perm_a [256];
	logic [7:0] perm_b [256];
	logic [7:0] perm_c [256];
	logic [7:0] perm_d [256];
	logic [LAT-1:0] vld_q;
	logic acc;

	assign busy = 1'b0;
	assign acc = start && (cmd == osn2d_pkg::CMD_EVAL);

	// write all four copies of the table
	always_ff @(posedge clk) begin
		if (start && cmd == osn2d_pkg::CMD_LOAD) begin
			perm_a[table_index] <= table_value;
			perm_b[table_index] <= table_value;
			perm_c[table_index] <= table_value;
			perm_d[table_index] <= table_value;
		end
	end

	// stage 1: skew products (sum times stretch, split into halves)
	logic signed [32:0] s_c;
	logic [23:0] x_s1, y_s1;
	logic [49:0] plo_s1;
	logic signed [49:0] phi_s1;
	assign s_c = 33'(x_coord) + 33'(y_coord);
	always_ff @(posedge clk) begin
		x_s1 <= x_coord[23:0];
		y_s1 <= y_coord[23:0];
		plo_s1 <= 50'({17'd0, s_c[15:0]} * {1'b0, osn2d_pkg::STRETCH_Q32});
		phi_s1 <= 50'($signed(s_c[32:16]) * $signed({1'b0, osn2d_pkg::STRETCH_Q32}));
	end

	// stage 2: skewed coordinates, low 56 bits suffice
	logic [55:0] p_c, ux_c, uy_c;
	logic [7:0] xb_s2, yb_s2;
	logic signed [27:0] xi_s2, yi_s2;
	assign p_c = 56'(plo_s1) + 56'({phi_s1, 16'd0});
	assign ux_c = {x_s1, 32'd0} - p_c;
	assign uy_c = {y_s1, 32'd0} - p_c;
	always_ff @(posedge clk) begin
		xb_s2 <= ux_c[55:48];
		yb_s2 <= uy_c[55:48];
		xi_s2 <= {4'd0, ux_c[47:24]};
		yi_s2 <= {4'd0, uy_c[47:24]};
	end

	// stage 3: squish product
	logic signed [53:0] sqp_s3;
	logic signed [27:0] xi_s3, yi_s3;
	logic [7:0] xb_s3, yb_s3;
	always_ff @(posedge clk) begin
		sqp_s3 <= 54'((xi_s2 + yi_s2) * SQ);
		xi_s3 <= xi_s2;
		yi_s3 <= yi_s2;
		xb_s3 <= xb_s2;
		yb_s3 <= yb_s2;
	end

	// stage 4: pick vertices
	logic signed [27:0] ins_c, dx0_c, dy0_c, z_c;
	logic signed [27:0] d_c [4][2];
	logic [7:0] vx_c [4], vy_c [4];
	logic signed [27:0] d_s4 [4][2];
	logic [7:0] vx_s4 [4], vy_s4 [4];
	always_comb begin
		ins_c = xi_s3 + yi_s3;
		dx0_c = xi_s3 + 28'(sqp_s3 >>> osn2d_pkg::GEO_BITS);
		dy0_c = yi_s3 + 28'(sqp_s3 >>> osn2d_pkg::GEO_BITS);
		vx_c[0] = xb_s3 + 8'd1; vy_c[0] = yb_s3;
		d_c[0][0] = dx0_c - ONE - SQ; d_c[0][1] = dy0_c - SQ;
		vx_c[1] = xb_s3; vy_c[1] = yb_s3 + 8'd1;
		d_c[1][0] = dx0_c - SQ; d_c[1][1] = dy0_c - ONE - SQ;
		vx_c[2] = xb_s3; vy_c[2] = yb_s3;
		d_c[2][0] = dx0_c; d_c[2][1] = dy0_c;
		if (ins_c <= ONE) begin
			z_c = ONE - ins_c;
			if (z_c > xi_s3 || z_c > yi_s3) begin
				if (xi_s3 > yi_s3) begin
					vx_c[3] = xb_s3 + 8'd1; vy_c[3] = yb_s3 - 8'd1;
					d_c[3][0] = dx0_c - ONE; d_c[3][1] = dy0_c + ONE;
				end else begin
					vx_c[3] = xb_s3 - 8'd1; vy_c[3] = yb_s3 + 8'd1;
					d_c[3][0] = dx0_c + ONE; d_c[3][1] = dy0_c - ONE;
				end
			end else begin
				vx_c[3] = xb_s3 + 8'd1; vy_c[3] = yb_s3 + 8'd1;
				d_c[3][0] = dx0_c - ONE - 2 * SQ; d_c[3][1] = dy0_c - ONE - 2 * SQ;
			end
		end else begin
			z_c = 2 * ONE - ins_c;
			if (z_c < xi_s3 || z_c < yi_s3) begin
				if (xi_s3 > yi_s3) begin
					vx_c[3] = xb_s3 + 8'd2; vy_c[3] = yb_s3;
					d_c[3][0] = dx0_c - 2 * ONE - 2 * SQ; d_c[3][1] = dy0_c - 2 * SQ;
				end else begin
					vx_c[3] = xb_s3; vy_c[3] = yb_s3 + 8'd2;
					d_c[3][0] = dx0_c - 2 * SQ; d_c[3][1] = dy0_c - 2 * ONE - 2 * SQ;
				end
			end else begin
				vx_c[3] = xb_s3; vy_c[3] = yb_s3;
				d_c[3][0] = dx0_c; d_c[3][1] = dy0_c;
			end
			vx_c[2] = xb_s3 + 8'd1; vy_c[2] = yb_s3 + 8'd1;
			d_c[2][0] = dx0_c - ONE - 2 * SQ; d_c[2][1] = dy0_c - ONE - 2 * SQ;
		end
	end

	// stage 5: first table lookup; stage 6: second lookup
	logic [7:0] vy_s5 [4], p1_s5 [4];
	logic [7:0] p2_s6 [4];
	logic signed [27:0] d_s5 [4][2], d_s6 [4][2];
	always_ff @(posedge clk) begin
		for (int v = 0; v < 4; v++) begin
			vx_s4[v] <= vx_c[v];
			vy_s4[v] <= vy_c[v];
			d_s4[v] <= d_c[v];
			vy_s5[v] <= vy_s4[v];
			d_s5[v] <= d_s4[v];
			d_s6[v] <= d_s5[v];
		end
	end

	// each vertex has its own copy, read once per lookup stage
	always_ff @(posedge clk) begin
		p1_s5[0] <= perm_a[vx_s4[0]];
		p2_s6[0] <= perm_a[8'(p1_s5[0] + vy_s5[0])];
		p1_s5[1] <= perm_b[vx_s4[1]];
		p2_s6[1] <= perm_b[8'(p1_s5[1] + vy_s5[1])];
		p1_s5[2] <= perm_c[vx_s4[2]];
		p2_s6[2] <= perm_c[8'(p1_s5[2] + vy_s5[2])];
		p1_s5[3] <= perm_d[vx_s4[3]];
		p2_s6[3] <= perm_d[8'(p1_s5[3] + vy_s5[3])];
	end

	// four vertex units, result at stage 10
	logic signed [63:0] term_c [4];
	for (genvar v = 0; v < 4; v++) begin : g_vert
		osn2d_vertex u_vert (
			.clk (clk),
			.dx  (d_s6[v][0]),
			.dy  (d_s6[v][1]),
			.gsel({p2_s6[v][1], p2_s6[v][3], p2_s6[v][2]}),
			.term(term_c[v])
		);
	end

	// stage 11: sum the vertex terms and add the offset
	logic signed [65:0] t_s11;
	always_ff @(posedge clk) begin
		t_s11 <= 66'(term_c[0]) + 66'(term_c[1]) + 66'(term_c[2]) + 66'(term_c[3])
			+ (66'sd47 <<< 48);
	end

	// stage 12: clip flags and divide by 94 * 2^32 through a reciprocal
	logic neg_s12, sat_s12;
	logic [45:0] qp_s12;
	always_ff @(posedge clk) begin
		neg_s12 <= t_s11[65];
		sat_s12 <= (t_s11 >= FULL_SCALE);
		qp_s12 <= 46'(t_s11[54:32]) * 46'(RECIP_94);
	end

	// stage 13: clip and register the result
	always_ff @(posedge clk) begin
		if (neg_s12) noise <= 16'd0;
		else if (sat_s12) noise <= 16'hFFFF;
		else noise <= qp_s12[44:29];
	end

	// valid bits travel with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end
	assign done = vld_q[LAT-1];

	a_busy_low: assert property (@(posedge clk) busy == 1'b0)
		else $error("busy raised");
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && cmd == osn2d_pkg::CMD_LOAD) |=> !vld_q[0])
		else $error("load produced a result");
	a_eval_lat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> ##12 done)
		else $error("result lost");

endmodule
